### src/assert_macros.svh
// Assertion macros for the RTL of the strip filter.
// Checks are compiled in unless SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that a condition holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
// Checks that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, cond, expr, msg)
`endif
`endif

### src/pwsf_pkg.sv
// Package for the punctuation and whitespace strip filter.
// Holds the item types and the token match functions; no dependencies.
`timescale 1ns / 1ps

package pwsf_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
    } t_out_item;

    localparam logic [7:0] LEAD_EF  = 8'hEF;
    localparam logic [7:0] LEAD_E3  = 8'hE3;
    localparam logic [7:0] LEAD_E2  = 8'hE2;
    localparam logic [7:0] LEAD_C2  = 8'hC2;
    localparam logic [7:0] MID_BC   = 8'hBC;
    localparam logic [7:0] MID_80   = 8'h80;
    localparam logic [7:0] TRAIL_B7 = 8'hB7;

    function automatic logic is_drop1(input logic [7:0] b);
        return (b == 8'h3A) || (b == 8'h2C) || (b == 8'h2E) || (b == 8'h27) ||
               (b == 8'h22) || (b == 8'h28) || (b == 8'h29) || (b == 8'h5B) ||
               (b == 8'h5D) || (b == 8'h2D) || (b == 8'h2F) || (b == 8'h20) ||
               (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic is_lead(input logic [7:0] b);
        return (b == LEAD_EF) || (b == LEAD_E3) || (b == LEAD_E2) || (b == LEAD_C2);
    endfunction

    function automatic logic is_pair_prefix(input logic [7:0] a, input logic [7:0] b);
        return ((a == LEAD_EF) && (b == MID_BC)) || ((a == LEAD_E3) && (b == MID_80)) ||
               ((a == LEAD_E2) && (b == MID_80));
    endfunction

    function automatic logic is_triple(input logic [7:0] a, input logic [7:0] m,
                                       input logic [7:0] b);
        logic ef_tok;
        logic e3_tok;
        logic e2_tok;
        ef_tok = (a == LEAD_EF) && (m == MID_BC) &&
                 ((b == 8'h9A) || (b == 8'h8C) || (b == 8'h88) || (b == 8'h89));
        e3_tok = (a == LEAD_E3) && (m == MID_80) &&
                 ((b == 8'h82) || (b == 8'h81) || (b == 8'h8C) || (b == 8'h8D));
        e2_tok = (a == LEAD_E2) && (m == MID_80) && (b == 8'hA6);
        return ef_tok || e3_tok || e2_tok;
    endfunction

endpackage

### src/punctuation_whitespace_strip_filter.sv
// Top level of the punctuation and whitespace strip filter.
// Depends on pwsf_pkg and assert_macros.svh.
//
//  channel  | valid   | stall   | payload
//  input    | i_valid | o_stall | i_data (t_in_item)
//  output   | o_valid | i_stall | o_data (t_out_item)
//
// An accepted item is registered and matched against the pending bytes; its
// zero to three results enter a four-entry output queue. One item per
// cycle is sustained while each item gives at most one result and i_stall
// is low; an item with more results holds the input until at most one
// entry is queued. Reset is synchronous and clears all control state.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module punctuation_whitespace_strip_filter
    import pwsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic [7:0] r_pend [2];
    logic [1:0] r_pcnt;
    t_out_item r_q [4];
    logic [2:0] r_cnt;

    logic      in_accept;
    logic      fire;
    logic      pop;
    t_out_item res [3];
    logic [1:0] nres;
    logic [1:0] wc;
    logic [7:0] w0;
    logic [7:0] w1;
    logic      need_single;
    t_out_item n_q [4];
    logic [2:0] n_cnt;
    logic [2:0] base;
    logic [2:0] idx;

    assign fire      = r_in_valid && (r_cnt <= 3'd1);
    assign o_stall   = r_in_valid && !fire;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = (r_cnt != 3'd0);
    assign o_data    = r_q[0];
    assign pop       = o_valid && !i_stall;

    always_comb begin
        res[0] = '0;
        res[1] = '0;
        res[2] = '0;
        nres = 2'd0;
        wc = 2'd0;
        w0 = r_pend[0];
        w1 = r_pend[1];
        need_single = 1'b0;
        unique case (r_pcnt)
            2'd2: begin
                if (!is_triple(r_pend[0], r_pend[1], r_in.data_byte)) begin
                    res[0] = '{out_byte: r_pend[0], byte_valid: 1'b1, last: 1'b0};
                    res[1] = '{out_byte: r_pend[1], byte_valid: 1'b1, last: 1'b0};
                    nres = 2'd2;
                    need_single = 1'b1;
                end
            end
            2'd1: begin
                if ((r_pend[0] == LEAD_C2) && (r_in.data_byte == TRAIL_B7)) begin
                    wc = 2'd0;
                end else if (is_pair_prefix(r_pend[0], r_in.data_byte)) begin
                    wc = 2'd2;
                    w1 = r_in.data_byte;
                end else begin
                    res[0] = '{out_byte: r_pend[0], byte_valid: 1'b1, last: 1'b0};
                    nres = 2'd1;
                    need_single = 1'b1;
                end
            end
            default: begin
                need_single = 1'b1;
            end
        endcase
        if (need_single) begin
            if (is_drop1(r_in.data_byte)) begin
                wc = 2'd0;
            end else if (is_lead(r_in.data_byte)) begin
                wc = 2'd1;
                w0 = r_in.data_byte;
            end else begin
                res[nres] = '{out_byte: r_in.data_byte, byte_valid: 1'b1, last: 1'b0};
                nres = nres + 2'd1;
            end
        end
        if (r_in.end_of_string) begin
            if (wc != 2'd0) begin
                res[nres] = '{out_byte: w0, byte_valid: 1'b1, last: 1'b0};
                nres = nres + 2'd1;
            end
            if (wc == 2'd2) begin
                res[nres] = '{out_byte: w1, byte_valid: 1'b1, last: 1'b0};
                nres = nres + 2'd1;
            end
            wc = 2'd0;
            if (nres == 2'd0) begin
                res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b0};
                nres = 2'd1;
            end
            res[nres - 2'd1].last = 1'b1;
        end
    end

    always_comb begin
        n_q = r_q;
        base = r_cnt;
        idx = 3'd0;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_q[2] = r_q[3];
            base = r_cnt - 3'd1;
        end
        if (fire) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < nres) begin
                    idx = base + 3'(k);
                    n_q[idx[1:0]] = res[k];
                end
            end
        end
        n_cnt = base + (fire ? {1'b0, nres} : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pcnt <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_pcnt <= wc;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_data;
        end
        if (fire) begin
            r_pend[0] <= w0;
            r_pend[1] <= w1;
        end
        r_q <= n_q;
    end

    `ASSERT_ALWAYS(a_queue_bound, r_cnt <= 3'd4, "Output queue count exceeds its depth.")
    `ASSERT_ALWAYS(a_pend_bound, r_pcnt != 2'd3, "Pending count exceeds two bytes.")
    `ASSERT_NEXT(a_eos_flush, fire && r_in.end_of_string, r_pcnt == 2'd0,
                 "Pending bytes remain after the end of a string.")
    `ASSERT_ALWAYS(a_pend_lead, (r_pcnt == 2'd0) || is_lead(r_pend[0]),
                   "Oldest pending byte is not a token lead byte.")

endmodule

### tb/tb.sv
// Self-checking bench for punctuation_whitespace_strip_filter, driven through both handshakes.
// It predicts the kept bytes of each item and compares them field by field with the outputs.
// Depends on pwsf_pkg and the filter RTL.
`timescale 1ns / 1ps

module tb;
    import pwsf_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int END_WAIT_CYCLES  = 20;
    localparam int NUM_DROP_TOKENS  = 25;
    localparam int NUM_MULTI_TOKENS = 10;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_drop_token;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    t_out_item  kept_bytes_q [$];
    logic [7:0] held_bytes [2];
    int         held_count;
    int         error_count;
    int         cycle_count;
    int         items_sent;
    bit         tx_gaps;
    bit         rx_gaps;
    bit         long_hold;

    punctuation_whitespace_strip_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    function automatic t_drop_token drop_token(input int idx);
        case (idx)
            0:       return '{2'd3, 8'hEF, 8'hBC, 8'h9A};
            1:       return '{2'd3, 8'hEF, 8'hBC, 8'h8C};
            2:       return '{2'd3, 8'hE3, 8'h80, 8'h82};
            3:       return '{2'd3, 8'hE3, 8'h80, 8'h81};
            4:       return '{2'd3, 8'hEF, 8'hBC, 8'h88};
            5:       return '{2'd3, 8'hEF, 8'hBC, 8'h89};
            6:       return '{2'd3, 8'hE3, 8'h80, 8'h8C};
            7:       return '{2'd3, 8'hE3, 8'h80, 8'h8D};
            8:       return '{2'd2, 8'hC2, 8'hB7, 8'h00};
            9:       return '{2'd3, 8'hE2, 8'h80, 8'hA6};
            10:      return '{2'd1, 8'h3A, 8'h00, 8'h00};
            11:      return '{2'd1, 8'h2C, 8'h00, 8'h00};
            12:      return '{2'd1, 8'h2E, 8'h00, 8'h00};
            13:      return '{2'd1, 8'h27, 8'h00, 8'h00};
            14:      return '{2'd1, 8'h22, 8'h00, 8'h00};
            15:      return '{2'd1, 8'h28, 8'h00, 8'h00};
            16:      return '{2'd1, 8'h29, 8'h00, 8'h00};
            17:      return '{2'd1, 8'h5B, 8'h00, 8'h00};
            18:      return '{2'd1, 8'h5D, 8'h00, 8'h00};
            19:      return '{2'd1, 8'h2D, 8'h00, 8'h00};
            20:      return '{2'd1, 8'h2F, 8'h00, 8'h00};
            21:      return '{2'd1, 8'h20, 8'h00, 8'h00};
            22:      return '{2'd1, 8'h09, 8'h00, 8'h00};
            23:      return '{2'd1, 8'h0A, 8'h00, 8'h00};
            default: return '{2'd1, 8'h0D, 8'h00, 8'h00};
        endcase
    endfunction

    // Returns the token length if the window starts with a token, 0 if it is a proper
    // prefix of one, and -1 otherwise.
    function automatic int match_window(input logic [7:0] w0, input logic [7:0] w1,
                                        input logic [7:0] w2, input int len);
        t_drop_token tok;
        bit          prefix;
        int          n;
        int          t;
        prefix = 1'b0;
        for (t = 0; t < NUM_DROP_TOKENS; t++) begin
            tok = drop_token(t);
            n = (len < int'(tok.len)) ? len : int'(tok.len);
            if ((w0 == tok.b0) && (n < 2 || w1 == tok.b1) && (n < 3 || w2 == tok.b2)) begin
                if (int'(tok.len) <= len) begin
                    return int'(tok.len);
                end
                prefix = 1'b1;
            end
        end
        return prefix ? 0 : -1;
    endfunction

    task automatic predict_kept_bytes(input t_in_item it);
        logic [7:0] win [3];
        t_out_item  res [3];
        int         len;
        int         cls;
        int         drop;
        int         nres;
        int         i;
        bit         waiting;
        win[0] = held_bytes[0];
        win[1] = held_bytes[1];
        win[2] = 8'h00;
        len = held_count;
        win[len] = it.data_byte;
        len++;
        nres = 0;
        waiting = 1'b0;
        while (len > 0 && !waiting) begin
            cls = match_window(win[0], win[1], win[2], len);
            if (cls == 0) begin
                waiting = 1'b1;
            end else begin
                if (cls < 0) begin
                    res[nres] = '{out_byte: win[0], byte_valid: 1'b1, last: 1'b0};
                    nres++;
                    drop = 1;
                end else begin
                    drop = cls;
                end
                for (i = 0; i < len - drop; i++) begin
                    win[i] = win[i + drop];
                end
                len -= drop;
            end
        end
        if (it.end_of_string) begin
            for (i = 0; i < len; i++) begin
                res[nres] = '{out_byte: win[i], byte_valid: 1'b1, last: 1'b0};
                nres++;
            end
            len = 0;
            if (nres == 0) begin
                res[0] = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b0};
                nres = 1;
            end
            res[nres - 1].last = 1'b1;
        end
        for (i = 0; i < nres; i++) begin
            kept_bytes_q = {kept_bytes_q, res[i]};
        end
        held_count = len;
        for (i = 0; i < len; i++) begin
            held_bytes[i] = win[i];
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Entered and left at a falling edge; valid stays high when items follow back to back.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: b, end_of_string: eos};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_kept_bytes(i_data);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (kept_bytes_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_string(input int max_len);
        logic [7:0]  str [$];
        t_drop_token tok;
        int          target;
        int          kind;
        int          k;
        target = $urandom_range(1, max_len);
        while (str.size() < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                tok = drop_token($urandom_range(0, 1) ? $urandom_range(0, NUM_MULTI_TOKENS - 1)
                                                      : $urandom_range(0, NUM_DROP_TOKENS - 1));
                str = {str, tok.b0};
                if (tok.len >= 2) str = {str, tok.b1};
                if (tok.len == 3) str = {str, tok.b2};
            end else if (kind <= 5) begin
                tok = drop_token($urandom_range(0, NUM_MULTI_TOKENS - 1));
                str = {str, tok.b0};
                if (tok.len == 3 && $urandom_range(0, 1)) str = {str, tok.b1};
                str = {str, (($urandom_range(0, 2) == 0) ? tok.b0
                                                         : 8'($urandom_range(0, 255)))};
            end else if (kind <= 7) begin
                str = {str, 8'($urandom_range(8'h21, 8'h7E))};
            end else begin
                str = {str, 8'($urandom_range(0, 255))};
            end
        end
        for (k = 0; k < str.size(); k++) begin
            send_byte(str[k], k == str.size() - 1);
        end
    endtask

    task automatic run_random_strings(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) send_random_string(16);
    endtask

    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h09, 1'b0);
        send_byte(8'h0A, 1'b0);
        send_byte(8'h0D, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBC, 1'b0);
        send_byte(8'h9A, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hB7, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hA6, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBC, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE3, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hE3, 1'b1);
        send_byte(8'h2C, 1'b1);
        send_byte(8'hC2, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hE3, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h8D, 1'b1);
    endtask

    task automatic test_random_with_idling();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random_strings(230);
    endtask

    task automatic test_output_hold();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        long_hold = 1'b1;
        run_random_strings(40);
    endtask

    task automatic test_sender_pause();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        run_random_strings(20);
        wait_for_drain();
        @(negedge i_clk);
        run_random_strings(20);
    endtask

    task automatic test_no_idling();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_random_strings(80);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (kept_bytes_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h valid %0b last %0b",
                                          o_data.out_byte, o_data.byte_valid, o_data.last));
            end else begin
                want = kept_bytes_q.pop_front();
                if (o_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte got %02h exp %02h",
                                              o_data.out_byte, want.out_byte));
                if (o_data.byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid got %0b exp %0b",
                                              o_data.byte_valid, want.byte_valid));
                if (o_data.last !== want.last)
                    report_mismatch($sformatf("last got %0b exp %0b", o_data.last, want.last));
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        held_bytes[0] = 8'h00;
        held_bytes[1] = 8'h00;
        held_count = 0;
        error_count = 0;
        items_sent = 0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        long_hold = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_with_idling();
        test_output_hold();
        test_sender_pause();
        test_no_idling();
        wait_for_drain();
        repeat (END_WAIT_CYCLES) @(negedge i_clk);
        if (error_count == 0 && kept_bytes_q.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/pwsf_pkg.sv
src/punctuation_whitespace_strip_filter.sv
tb/tb.sv
